[rtl/core/assert_macros.svh]
// Assertion helper macros for the decimal expression calculator RTL.
// Every user supplies clk_i and rst_ni in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain invariant.
`define DC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent in the next cycle.
`define DC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dcalc_pkg.sv]
// Shared types and constants for the decimal expression calculator.
// No dependencies; used by dcalc_alu and decimal_expression_calculator.
`default_nettype none

package dcalc_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int VALUE_WIDTH       = 32;

  // ASCII codes of interest
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_OP    = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_DIGIT,
    TS_START,
    TS_WAIT
  } top_state_e;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIX,
    AS_DONE
  } alu_state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    status;
  } out_t;

  // Control from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    logic ack;
    op_e  op;
    logic op_seen;
  } alu_req_t;

  // Status from the arithmetic unit back to the sequencer
  typedef struct packed {
    logic    valid;
    status_e status;
  } alu_rsp_t;

endpackage

`default_nettype wire

[rtl/core/dcalc_alu.sv]
// Bit-serial arithmetic unit: add/sub in one step, shift-add multiply and
// restoring divide/remainder one bit per cycle. Depends on dcalc_pkg.
`default_nettype none
`include "assert_macros.svh"

module dcalc_alu #(
  parameter int OperandWidth = dcalc_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dcalc_pkg::alu_req_t     req_i,
  input  wire logic [OperandWidth-1:0] a_i,
  input  wire logic [OperandWidth-1:0] b_i,
  output dcalc_pkg::alu_rsp_t          rsp_o,
  output logic [OperandWidth-1:0]      res_o
);
  import dcalc_pkg::*;

  localparam int W    = OperandWidth;
  localparam int CntW = $clog2(W);

  alu_state_e     state_q, state_d;
  op_e            op_q, op_d;
  status_e        status_q, status_d;
  logic [W-1:0]   x_q, x_d;    // multiplicand / divisor magnitude
  logic [W-1:0]   y_q, y_d;    // multiplier / quotient
  logic [W-1:0]   z_q, z_d;    // product accumulator / partial remainder
  logic [W-1:0]   res_q, res_d;
  logic           na_q, na_d, nb_q, nb_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     div_sh, div_trial;
  logic           last_bit;

  assign mag_a     = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign mag_b     = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign div_sh    = {z_q, y_q[W-1]};
  assign div_trial = div_sh - {1'b0, x_q};
  assign last_bit  = (cnt_q == CntW'(W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    res_q    <= res_d;
    na_q     <= na_d;
    nb_q     <= nb_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    res_d    = res_q;
    na_d     = na_q;
    nb_d     = nb_q;
    cnt_d    = cnt_q;

    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d     = req_i.op;
          status_d = STAT_OK;
          res_d    = '0;
          cnt_d    = '0;
          na_d     = a_i[W-1];
          nb_d     = b_i[W-1];
          state_d  = AS_DONE;
          if (!req_i.op_seen) begin
            status_d = STAT_NO_OP;
          end else begin
            case (req_i.op)
              OP_ADD: res_d = a_i + b_i;
              OP_SUB: res_d = a_i - b_i;
              OP_MUL: begin
                x_d     = a_i;
                y_d     = b_i;
                z_d     = '0;
                state_d = AS_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (b_i == '0) begin
                  status_d = STAT_DIV_ZERO;
                end else begin
                  x_d     = mag_b;
                  y_d     = mag_a;
                  z_d     = '0;
                  state_d = AS_DIV;
                end
              end
              default: status_d = STAT_NO_OP;
            endcase
          end
        end
      end
      AS_MUL: begin
        if (y_q[0]) z_d = z_q + x_q;
        x_d   = {x_q[W-2:0], 1'b0};
        y_d   = {1'b0, y_q[W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (last_bit) state_d = AS_FIX;
      end
      AS_DIV: begin
        if (!div_trial[W]) begin
          z_d = div_trial[W-1:0];
          y_d = {y_q[W-2:0], 1'b1};
        end else begin
          z_d = div_sh[W-1:0];
          y_d = {y_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (last_bit) state_d = AS_FIX;
      end
      AS_FIX: begin
        case (op_q)
          OP_DIV:  res_d = (na_q ^ nb_q) ? (W'(0) - y_q) : y_q;
          OP_MOD:  res_d = na_q ? (W'(0) - z_q) : z_q;
          default: res_d = z_q;
        endcase
        state_d = AS_DONE;
      end
      AS_DONE: begin
        if (req_i.ack) state_d = AS_IDLE;
      end
      default: state_d = AS_IDLE;
    endcase
  end

  assign rsp_o.valid  = (state_q == AS_DONE);
  assign rsp_o.status = status_q;
  assign res_o        = res_q;

  `DC_ASSERT(a_start_idle, !req_i.start || state_q == AS_IDLE,
             "ALU started while busy")
  `DC_ASSERT(a_err_zero, !rsp_o.valid || status_q == STAT_OK || res_q == '0,
             "ALU error result not zero")
  `DC_ASSERT_NEXT(a_loop_cnt, state_q == AS_IDLE && req_i.start, cnt_q == '0,
                  "bit counter not cleared at start")

endmodule

`default_nettype wire

[rtl/core/decimal_expression_calculator.sv]
// Top level of the decimal expression calculator: character sequencer,
// operand registers and output register. Depends on dcalc_pkg, dcalc_alu.
`default_nettype none
`include "assert_macros.svh"

// Takes an expression one ASCII character per transaction. Digits build the
// left operand until the first of + - * / %, then the right operand; later
// operators and all other characters are ignored. Operands wrap modulo
// 2^OperandWidth. The transaction flagged last_char yields one result:
// value (32-bit two's complement, the OperandWidth-bit result sign extended)
// and status (0 ok, 1 no operator, 2 division or remainder by zero, value 0
// on error); all operand state is then cleared for the next expression.
// Steps: a non-digit character is handled in TS_IDLE alone; a digit also
// passes TS_DIGIT (x5 then x2 + digit, one wide add each). After the last
// character, TS_START launches dcalc_alu, and + and - already finish in it,
// while * / % then run the bit-serial loop of dcalc_alu over every operand
// bit plus a sign-fix step; TS_WAIT then moves the result into the output
// register once that register is free. No character is taken while a
// result is being computed; a finished result waits in the output register
// while input resumes.
module decimal_expression_calculator #(
  parameter int OperandWidth = dcalc_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dcalc_pkg::in_t  in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dcalc_pkg::out_t      out_o
);
  import dcalc_pkg::*;

  localparam int W = OperandWidth;

  top_state_e   state_q, state_d;
  logic [W-1:0] left_q, left_d;
  logic [W-1:0] right_q, right_d;
  op_e          op_q, op_d;
  logic         op_seen_q, op_seen_d;
  logic [W-1:0] five_q, five_d;     // selected operand times five
  logic [3:0]   dig_q, dig_d;
  logic         last_q, last_d;
  logic         out_valid_q, out_valid_d;
  out_t         out_q, out_d;

  logic         accept;
  logic         is_digit;
  logic         is_oper;
  op_e          oper;
  logic [W-1:0] sel_opnd;
  logic [W-1:0] digit_sum;
  logic         load_out;
  logic [W+VALUE_WIDTH-1:0] res_ext;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] alu_res;

  dcalc_alu #(
    .OperandWidth(OperandWidth)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (left_q),
    .b_i    (right_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // Character decode
  assign is_digit = (in_i.char_code >= CHAR_ZERO) && (in_i.char_code <= CHAR_NINE);

  always_comb begin
    is_oper = 1'b1;
    oper    = OP_ADD;
    case (in_i.char_code)
      CHAR_PLUS:    oper = OP_ADD;
      CHAR_MINUS:   oper = OP_SUB;
      CHAR_STAR:    oper = OP_MUL;
      CHAR_SLASH:   oper = OP_DIV;
      CHAR_PERCENT: oper = OP_MOD;
      default:      is_oper = 1'b0;
    endcase
  end

  // ready is high exactly in TS_IDLE
  assign accept    = in_valid_i && (state_q == TS_IDLE);
  assign sel_opnd  = op_seen_q ? right_q : left_q;
  assign digit_sum = {five_q[W-2:0], 1'b0} + W'(dig_q);
  assign load_out  = (state_q == TS_WAIT) && alu_rsp.valid
                     && (!out_valid_q || out_ready_i);
  assign res_ext   = {{VALUE_WIDTH{alu_res[W-1]}}, alu_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      left_q      <= '0;
      right_q     <= '0;
      op_q        <= OP_ADD;
      op_seen_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      right_q     <= right_d;
      op_q        <= op_d;
      op_seen_q   <= op_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    five_q <= five_d;
    dig_q  <= dig_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    right_d     = right_q;
    op_d        = op_q;
    op_seen_d   = op_seen_q;
    five_d      = five_q;
    dig_d       = dig_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    alu_req     = '{start: 1'b0, ack: 1'b0, op: op_q, op_seen: op_seen_q};

    case (state_q)
      TS_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (is_digit) begin
            // first half of operand * 10 + digit
            five_d  = sel_opnd + (sel_opnd << 2);
            dig_d   = 4'(in_i.char_code - CHAR_ZERO);
            last_d  = in_i.last_char;
            state_d = TS_DIGIT;
          end else begin
            if (!op_seen_q && is_oper) begin
              op_d      = oper;
              op_seen_d = 1'b1;
            end
            if (in_i.last_char) state_d = TS_START;
          end
        end
      end
      TS_DIGIT: begin
        if (op_seen_q) right_d = digit_sum;
        else           left_d  = digit_sum;
        state_d = last_q ? TS_START : TS_IDLE;
      end
      TS_START: begin
        // unit latches operands now; clear for the next expression
        alu_req.start = 1'b1;
        left_d    = '0;
        right_d   = '0;
        op_d      = OP_ADD;
        op_seen_d = 1'b0;
        state_d   = TS_WAIT;
      end
      TS_WAIT: begin
        if (load_out) begin
          alu_req.ack  = 1'b1;
          out_d.value  = signed'(res_ext[VALUE_WIDTH-1:0]);
          out_d.status = alu_rsp.status;
          out_valid_d  = 1'b1;
          state_d      = TS_IDLE;
        end
      end
      default: state_d = TS_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `DC_ASSERT(a_err_value, !out_valid_o || out_o.status == STAT_OK || out_o.value == '0,
             "error result carries nonzero value")
  `DC_ASSERT_NEXT(a_load_src, !out_valid_o || out_ready_i,
                  !out_valid_o || $past(state_q == TS_WAIT),
                  "result appeared without a finished computation")
  `DC_ASSERT_NEXT(a_start_clear, state_q == TS_START,
                  !op_seen_q && left_q == '0 && right_q == '0,
                  "operand state not cleared after launch")

endmodule

`default_nettype wire
